// ===== design/linear_probing_hash_table_top_macros.svh =====
// assertion helpers for the hash table block
`ifndef LINEAR_PROBING_HASH_TABLE_TOP_MACROS_SVH
`define LINEAR_PROBING_HASH_TABLE_TOP_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define LPHT_ASSERT_IMPL(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define LPHT_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`else

`define LPHT_ASSERT_IMPL(name, clk, rst_n, ante, cons, msg)
`define LPHT_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg)

`endif

`endif

// ===== design/lpht_pkg.sv =====
package lpht_pkg;

    localparam int KEY_W       = 64;
    localparam int VAL_W       = 64;
    localparam int FILL_W      = 11;
    localparam int IN_TDATA_W  = KEY_W + VAL_W;
    localparam int OUT_TDATA_W = VAL_W;

    localparam logic [63:0]       HASH_MUL     = 64'h9E37_79B9_7F4A_7C15;
    localparam logic [FILL_W-1:0] MAX_FILL_RST = 11'd768;

    // apb register map
    localparam int APB_DW    = 32;
    localparam int APB_AW    = 3;
    localparam int REG_IDX_W = APB_AW - 2;
    localparam logic [REG_IDX_W-1:0] REG_MAX_FILL = '0;

    typedef enum logic {
        FUNC_INSERT = 1'b0,
        FUNC_LOOKUP = 1'b1
    } t_func;

    typedef enum logic [1:0] {
        ST_INSERTED  = 2'd0,
        ST_FULL      = 2'd1,
        ST_FOUND     = 2'd2,
        ST_NOT_FOUND = 2'd3
    } t_status;

    typedef struct packed {
        logic    clr_step;
        logic    load;
        logic    hash_step;
        logic    rd;
        logic    advance;
        logic    ins_wr;
        logic    res_ld;
        t_status res_status;
        logic    out_ld;
    } t_dp_cmd;

    typedef struct packed {
        logic  clr_last;
        logic  clr_done;
        logic  hash_last;
        t_func func;
        logic  fill_ok;
        logic  rd_vld;
        logic  key_hit;
        logic  lap_last;
    } t_dp_sts;

endpackage

// ===== design/lpht_cfg.sv =====
module lpht_cfg (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_psel,
    input  logic                             i_penable,
    input  logic                             i_pwrite,
    input  logic [lpht_pkg::APB_AW-1:0]      i_paddr,
    input  logic [lpht_pkg::APB_DW-1:0]      i_pwdata,
    output logic [lpht_pkg::APB_DW-1:0]      o_prdata,
    output logic                             o_pready,
    output logic [lpht_pkg::FILL_W-1:0]      o_max_fill
);
    import lpht_pkg::*;

    logic [FILL_W-1:0]    r_max_fill;
    logic [REG_IDX_W-1:0] reg_idx;
    logic                 wr_fire;

    assign o_pready = 1'b1;
    assign reg_idx  = i_paddr[APB_AW-1:2];
    assign wr_fire  = i_psel & i_penable & i_pwrite & o_pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_fill <= MAX_FILL_RST;
        end else if (wr_fire && reg_idx == REG_MAX_FILL) begin
            r_max_fill <= i_pwdata[FILL_W-1:0];
        end
    end

    assign o_prdata   = (reg_idx == REG_MAX_FILL) ? APB_DW'(r_max_fill) : '0;
    assign o_max_fill = r_max_fill;

endmodule

// ===== design/lpht_dp.sv =====
`include "linear_probing_hash_table_top_macros.svh"

module lpht_dp #(
    parameter int CAPACITY = 1024
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  lpht_pkg::t_dp_cmd                    i_cmd,
    output lpht_pkg::t_dp_sts                    o_sts,
    input  logic [lpht_pkg::FILL_W-1:0]          i_max_fill,
    input  logic [lpht_pkg::IN_TDATA_W-1:0]      i_in_tdata,
    input  logic                                 i_in_tuser,
    output logic [lpht_pkg::OUT_TDATA_W-1:0]     o_out_tdata,
    output logic [1:0]                           o_out_tuser
);
    import lpht_pkg::*;

    localparam int SW   = $clog2(CAPACITY);
    localparam int LG   = $clog2(CAPACITY + 1) - 1;
    localparam int CW   = $clog2(CAPACITY + 1);
    localparam int CMPW = (CW > FILL_W) ? CW : FILL_W;

    localparam logic [SW-1:0] LAST_SLOT = SW'(CAPACITY - 1);

    // hash phases: one 32x32 partial product per step
    localparam logic [1:0] HP_LL = 2'd0;
    localparam logic [1:0] HP_LH = 2'd1;
    localparam logic [1:0] HP_HL = 2'd2;
    localparam logic [1:0] HP_END = 2'd3;

    // storage
    logic [KEY_W-1:0] r_key_mem [CAPACITY];
    logic [VAL_W-1:0] r_val_mem [CAPACITY];
    logic             r_vld_mem [CAPACITY];

    logic [KEY_W-1:0] r_key;
    logic [VAL_W-1:0] r_val;
    t_func            r_func;

    logic [1:0]       r_hash_ph;
    logic [63:0]      r_prod;
    logic [63:0]      r_hash;
    logic [63:0]      n_hash;
    logic [31:0]      mul_a;
    logic [31:0]      mul_b;
    logic [63:0]      mul_p;

    logic [SW-1:0]    r_slot;
    logic [SW-1:0]    r_probes;
    logic [SW-1:0]    r_clr_idx;
    logic             r_clr_done;
    logic [CW-1:0]    r_entry_cnt;

    logic [KEY_W-1:0] r_rd_key;
    logic [VAL_W-1:0] r_rd_val;
    logic             r_rd_vld;

    t_status          r_res_status;
    logic [VAL_W-1:0] r_res_value;
    t_status          r_out_status;
    logic [VAL_W-1:0] r_out_value;

    logic             vld_we;
    logic [SW-1:0]    vld_wa;

    // input capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_key  <= i_in_tdata[KEY_W-1:0];
            r_val  <= i_in_tdata[IN_TDATA_W-1:KEY_W];
            r_func <= t_func'(i_in_tuser);
        end
    end

    // multiplicative hash, low 64 bits of key * HASH_MUL
    always_comb begin
        unique case (r_hash_ph)
            HP_LL:   begin mul_a = r_key[31:0];  mul_b = HASH_MUL[31:0];  end
            HP_LH:   begin mul_a = r_key[31:0];  mul_b = HASH_MUL[63:32]; end
            HP_HL:   begin mul_a = r_key[63:32]; mul_b = HASH_MUL[31:0];  end
            default: begin mul_a = r_key[63:32]; mul_b = HASH_MUL[31:0];  end
        endcase
    end

    assign mul_p  = mul_a * mul_b;
    assign n_hash = r_hash + {r_prod[31:0], 32'b0};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hash_ph <= HP_LL;
        end else if (i_cmd.load) begin
            r_hash_ph <= HP_LL;
        end else if (i_cmd.hash_step) begin
            r_hash_ph <= r_hash_ph + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.hash_step) begin
            r_prod <= mul_p;
            if (r_hash_ph == HP_LH) begin
                r_hash <= r_prod;
            end else if (r_hash_ph == HP_HL) begin
                r_hash <= n_hash;
            end
        end
    end

    // probe position
    always_ff @(posedge i_clk) begin
        if (i_cmd.hash_step && r_hash_ph == HP_END) begin
            r_slot   <= SW'(n_hash[63 -: LG]);
            r_probes <= '0;
        end else if (i_cmd.advance) begin
            r_slot   <= (r_slot == LAST_SLOT) ? '0 : r_slot + 1'b1;
            r_probes <= r_probes + 1'b1;
        end
    end

    // clearing pass over the valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_idx  <= '0;
            r_clr_done <= 1'b0;
        end else if (i_cmd.clr_step) begin
            if (r_clr_idx == LAST_SLOT) begin
                r_clr_done <= 1'b1;
            end else begin
                r_clr_idx <= r_clr_idx + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry_cnt <= '0;
        end else if (i_cmd.ins_wr) begin
            r_entry_cnt <= r_entry_cnt + 1'b1;
        end
    end

    assign vld_we = i_cmd.clr_step | i_cmd.ins_wr;
    assign vld_wa = i_cmd.clr_step ? r_clr_idx : r_slot;

    always_ff @(posedge i_clk) begin
        if (vld_we) begin
            r_vld_mem[vld_wa] <= i_cmd.ins_wr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.ins_wr) begin
            r_key_mem[r_slot] <= r_key;
            r_val_mem[r_slot] <= r_val;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd) begin
            r_rd_key <= r_key_mem[r_slot];
            r_rd_val <= r_val_mem[r_slot];
            r_rd_vld <= r_vld_mem[r_slot];
        end
    end

    // result and output word
    always_ff @(posedge i_clk) begin
        if (i_cmd.res_ld) begin
            r_res_status <= i_cmd.res_status;
            r_res_value  <= (i_cmd.res_status == ST_FOUND) ? r_rd_val : '0;
        end
        if (i_cmd.out_ld) begin
            r_out_status <= r_res_status;
            r_out_value  <= r_res_value;
        end
    end

    assign o_out_tdata = r_out_value;
    assign o_out_tuser = r_out_status;

    always_comb begin
        o_sts           = '0;
        o_sts.clr_last  = (r_clr_idx == LAST_SLOT);
        o_sts.clr_done  = r_clr_done;
        o_sts.hash_last = (r_hash_ph == HP_END);
        o_sts.func      = r_func;
        o_sts.fill_ok   = CMPW'(r_entry_cnt) < CMPW'(i_max_fill);
        o_sts.rd_vld    = r_rd_vld;
        o_sts.key_hit   = (r_rd_key == r_key);
        o_sts.lap_last  = (r_probes == LAST_SLOT);
    end

    `LPHT_ASSERT_IMPL(a_cnt_step, i_clk, i_rst_n, $past(i_rst_n) && (r_entry_cnt != $past(r_entry_cnt)), r_entry_cnt == $past(r_entry_cnt) + 1'b1, "entry count moved by more than one")
    `LPHT_ASSERT_IMPL(a_cnt_range, i_clk, i_rst_n, 1'b1, r_entry_cnt <= CAPACITY, "entry count above capacity")
    `LPHT_ASSERT_IMPL(a_no_overwrite, i_clk, i_rst_n, i_cmd.ins_wr, !r_rd_vld && r_clr_done, "insert into an occupied slot")

endmodule

// ===== design/lpht_ctrl.sv =====
`include "linear_probing_hash_table_top_macros.svh"

module lpht_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_s_tvalid,
    output logic               o_s_tready,
    output logic               o_m_tvalid,
    input  logic               i_m_tready,
    input  lpht_pkg::t_dp_sts  i_sts,
    output lpht_pkg::t_dp_cmd  o_cmd
);
    import lpht_pkg::*;

    typedef enum logic [5:0] {
        S_CLEAR = 6'b000001,
        S_IDLE  = 6'b000010,
        S_HASH  = 6'b000100,
        S_READ  = 6'b001000,
        S_CHECK = 6'b010000,
        S_DONE  = 6'b100000
    } t_state;

    t_state  r_state;
    t_state  n_state;
    logic    r_out_valid;
    logic    s_fire;
    t_dp_cmd cmd;

    assign o_s_tready = (r_state == S_IDLE);
    assign s_fire     = i_s_tvalid & o_s_tready;

    always_comb begin
        n_state        = r_state;
        cmd            = '0;
        cmd.res_status = ST_INSERTED;
        unique case (r_state)
            S_CLEAR: begin
                cmd.clr_step = 1'b1;
                if (i_sts.clr_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (s_fire) begin
                    cmd.load = 1'b1;
                    n_state  = S_HASH;
                end
            end
            S_HASH: begin
                cmd.hash_step = 1'b1;
                if (i_sts.hash_last) begin
                    if (i_sts.func == FUNC_INSERT && !i_sts.fill_ok) begin
                        cmd.res_ld     = 1'b1;
                        cmd.res_status = ST_FULL;
                        n_state        = S_DONE;
                    end else begin
                        n_state = S_READ;
                    end
                end
            end
            S_READ: begin
                cmd.rd  = 1'b1;
                n_state = S_CHECK;
            end
            S_CHECK: begin
                if (!i_sts.rd_vld) begin
                    // empty slot ends the run for both operations
                    cmd.res_ld = 1'b1;
                    if (i_sts.func == FUNC_INSERT) begin
                        cmd.ins_wr     = 1'b1;
                        cmd.res_status = ST_INSERTED;
                    end else begin
                        cmd.res_status = ST_NOT_FOUND;
                    end
                    n_state = S_DONE;
                end else if (i_sts.func == FUNC_LOOKUP && i_sts.key_hit) begin
                    cmd.res_ld     = 1'b1;
                    cmd.res_status = ST_FOUND;
                    n_state        = S_DONE;
                end else if (i_sts.lap_last) begin
                    cmd.res_ld     = 1'b1;
                    cmd.res_status = (i_sts.func == FUNC_INSERT) ? ST_FULL : ST_NOT_FOUND;
                    n_state        = S_DONE;
                end else begin
                    cmd.advance = 1'b1;
                    n_state     = S_READ;
                end
            end
            S_DONE: begin
                if (!r_out_valid || i_m_tready) begin
                    cmd.out_ld = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: n_state = S_CLEAR;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (cmd.out_ld) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_cmd      = cmd;

    `LPHT_ASSERT_IMPL(a_take_after_clear, i_clk, i_rst_n, s_fire, i_sts.clr_done, "word taken before clearing pass finished")
    `LPHT_ASSERT_IMPL(a_out_from_done, i_clk, i_rst_n, $past(i_rst_n) && $rose(r_out_valid), $past(r_state == S_DONE), "result shown without finishing an item")

endmodule

// ===== design/linear_probing_hash_table_top.sv =====
// channel   dir  handshake                    contents
// s_axis    in   s_axis_tvalid/s_axis_tready  tdata key,value  tuser func
// m_axis    out  m_axis_tvalid/m_axis_tready  tdata found_value  tuser status
// apb       in   psel/penable/pwrite/pready   max_fill at byte address 0
//
// one item at a time: each item takes 4 hash steps on one 32x32 multiplier;
// a refused insert then goes to its result, any other item then takes a read
// state and a compare state per slot that it probes on the memory port
// after reset a clearing pass over all CAPACITY slots zeroes the valid bits; no word
// is accepted until it ends, apb writes are taken throughout
// a finished result waits in the output register while m_axis_tready is low
module linear_probing_hash_table_top #(
    parameter int CAPACITY = 1024
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  logic [lpht_pkg::IN_TDATA_W-1:0]      s_axis_tdata,  // key, value
    input  logic [0:0]                           s_axis_tuser,  // func
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    output logic [lpht_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,  // found_value
    output logic [1:0]                           m_axis_tuser,  // status
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [lpht_pkg::APB_AW-1:0]          paddr,
    input  logic [lpht_pkg::APB_DW-1:0]          pwdata,
    output logic [lpht_pkg::APB_DW-1:0]          prdata,
    output logic                                 pready
);
    import lpht_pkg::*;

    t_dp_cmd           cmd;
    t_dp_sts           sts;
    logic [FILL_W-1:0] max_fill;

    lpht_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_psel     (psel),
        .i_penable  (penable),
        .i_pwrite   (pwrite),
        .i_paddr    (paddr),
        .i_pwdata   (pwdata),
        .o_prdata   (prdata),
        .o_pready   (pready),
        .o_max_fill (max_fill)
    );

    lpht_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_axis_tvalid),
        .o_s_tready (s_axis_tready),
        .o_m_tvalid (m_axis_tvalid),
        .i_m_tready (m_axis_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    lpht_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_max_fill  (max_fill),
        .i_in_tdata  (s_axis_tdata),
        .i_in_tuser  (s_axis_tuser[0]),
        .o_out_tdata (m_axis_tdata),
        .o_out_tuser (m_axis_tuser)
    );

endmodule
